### rtl/core/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants, codes and control structs of the block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int HEADER_BYTES = 28;
   localparam int LINK_BYTES   = 8;
   localparam int ALIGN_BYTES  = 4;

   localparam int ADDR_W   = 32;
   localparam int BYTES_W  = 32;
   localparam int PAY_W    = 16;
   localparam int STRIDE_W = 17;
   localparam int IDX_W    = $clog2(MAX_BLOCKS);
   localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
   localparam int OUT_CNT_W = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 32;

   typedef enum logic [1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_INIT  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_BADCFG    = 3'd2,
      ST_NOINIT    = 3'd3,
      ST_UNDERFLOW = 3'd4
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BYTES   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAYLOAD_BYTES = 2'd2;

   typedef struct packed {
      logic [ADDR_W-1:0]  base;
      logic [BYTES_W-1:0] bytes;
      logic [PAY_W-1:0]   payload;
   } cfg_type;

   typedef struct packed {
      logic             done;
      logic             cfg_ok;
      logic [CNT_W-1:0] count;
   } fill_stat_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  addr;
      logic [ADDR_W-1:0] data;
   } ram_wr_type;

   function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
      return (32'(i) + 32'd1 >= 32'(MAX_BLOCKS)) ? '0 : IDX_W'(32'(i) + 32'd1);
   endfunction

endpackage

### rtl/core/fbpa_if.sv
// ----------------------------------------------------------------------------
// fbpa_req_if / fbpa_rsp_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface fbpa_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 command;
   logic [fbpa_pkg::ADDR_W-1:0] free_addr;

   modport source (output valid, output command, output free_addr, input ready);
   modport sink   (input valid, input command, input free_addr, output ready);
endinterface

interface fbpa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fbpa_pkg::ADDR_W-1:0]    block_addr;
   logic [2:0]                    status;
   logic [fbpa_pkg::OUT_CNT_W-1:0] total_blocks;
   logic [fbpa_pkg::OUT_CNT_W-1:0] blocks_in_use;

   modport source (output valid, output block_addr, output status,
                   output total_blocks, output blocks_in_use, input ready);
   modport sink   (input valid, input block_addr, input status,
                   input total_blocks, input blocks_in_use, output ready);
endinterface

### rtl/core/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// Free list storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fbpa_ram (
   input  logic                           clock,
   input  fbpa_pkg::ram_wr_type           wr,
   input  logic [fbpa_pkg::IDX_W-1:0]     rd_addr,
   output logic [fbpa_pkg::ADDR_W-1:0]    rd_data
);

   logic [fbpa_pkg::ADDR_W-1:0] mem [fbpa_pkg::MAX_BLOCKS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/core/fbpa_fill_seq.sv
// ----------------------------------------------------------------------------
// fbpa_fill_seq
// Initialise sequencer: checks the configuration, then divides and fills the
// free list by repeated subtract/add on one shared 33-bit adder.
// ----------------------------------------------------------------------------
module fbpa_fill_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  fbpa_pkg::cfg_type         cfg,
   output fbpa_pkg::fill_stat_type   stat,
   output fbpa_pkg::ram_wr_type      wr
);

   localparam logic [fbpa_pkg::ADDR_W-1:0] ALIGN_MASK = 32'(fbpa_pkg::ALIGN_BYTES - 1);
   localparam logic [fbpa_pkg::STRIDE_W-1:0] STRIDE_MASK =
      fbpa_pkg::STRIDE_W'(fbpa_pkg::ALIGN_BYTES - 1);
   localparam logic [fbpa_pkg::STRIDE_W-1:0] STRIDE_PAD =
      fbpa_pkg::STRIDE_W'(fbpa_pkg::LINK_BYTES + fbpa_pkg::ALIGN_BYTES - 1);
   localparam logic [fbpa_pkg::ADDR_W-1:0] HDR = 32'(fbpa_pkg::HEADER_BYTES);
   localparam logic [fbpa_pkg::ADDR_W-1:0] FIRST_OFS =
      32'(fbpa_pkg::HEADER_BYTES + fbpa_pkg::LINK_BYTES);
   localparam logic [fbpa_pkg::CNT_W-1:0] CNT_MAX = fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS);

   typedef enum logic [2:0] {
      F_IDLE, F_REM, F_BASE, F_SUB, F_ADD, F_DONE
   } fstate_type;

   fstate_type                       state_ff, state_in;
   logic [fbpa_pkg::STRIDE_W-1:0]    stride_ff, stride_in;
   logic [fbpa_pkg::BYTES_W-1:0]     rem_ff, rem_in;
   logic [fbpa_pkg::ADDR_W-1:0]      addr_ff, addr_in;
   logic [fbpa_pkg::CNT_W-1:0]       count_ff, count_in;
   logic                             ok_ff, ok_in;

   // shared adder
   logic                          alu_sub;
   logic [fbpa_pkg::ADDR_W-1:0]   alu_a, alu_b;
   logic [fbpa_pkg::ADDR_W:0]     alu_sum;
   logic                          cfg_good;

   assign cfg_good = (cfg.base != '0) && ((cfg.base & ALIGN_MASK) == '0) &&
                     (cfg.bytes > HDR) && (cfg.payload != '0);

   always_comb begin
      alu_sub = 1'b1;
      alu_a   = rem_ff;
      alu_b   = 32'(stride_ff);
      case (state_ff)
         F_REM: begin
            alu_a = cfg.bytes;
            alu_b = HDR;
         end
         F_BASE: begin
            alu_sub = 1'b0;
            alu_a   = cfg.base;
            alu_b   = FIRST_OFS;
         end
         F_ADD: begin
            alu_sub = 1'b0;
            alu_a   = addr_ff;
         end
         default: ;
      endcase
      alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + 33'(alu_sub);
   end

   always_comb begin
      state_in  = state_ff;
      stride_in = stride_ff;
      rem_in    = rem_ff;
      addr_in   = addr_ff;
      count_in  = count_ff;
      ok_in     = ok_ff;
      wr.en     = 1'b0;
      wr.addr   = count_ff[fbpa_pkg::IDX_W-1:0];
      wr.data   = addr_ff;
      case (state_ff)
         F_IDLE: begin
            if (start) begin
               ok_in     = cfg_good;
               count_in  = '0;
               stride_in = ({1'b0, cfg.payload} + STRIDE_PAD) & ~STRIDE_MASK;
               state_in  = cfg_good ? F_REM : F_DONE;
            end
         end
         F_REM: begin
            rem_in   = alu_sum[fbpa_pkg::ADDR_W-1:0];
            state_in = F_BASE;
         end
         F_BASE: begin
            addr_in  = alu_sum[fbpa_pkg::ADDR_W-1:0];
            state_in = F_SUB;
         end
         F_SUB: begin
            // carry out set: remainder still holds one more block
            if (alu_sum[fbpa_pkg::ADDR_W] && (count_ff != CNT_MAX)) begin
               wr.en    = 1'b1;
               rem_in   = alu_sum[fbpa_pkg::ADDR_W-1:0];
               count_in = count_ff + 1'b1;
               state_in = F_ADD;
            end else begin
               state_in = F_DONE;
            end
         end
         F_ADD: begin
            addr_in  = alu_sum[fbpa_pkg::ADDR_W-1:0];
            state_in = F_SUB;
         end
         F_DONE: begin
            state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         count_ff <= '0;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ok_ff    <= ok_in;
      end
      stride_ff <= stride_in;
      rem_ff    <= rem_in;
      addr_ff   <= addr_in;
   end

   assign stat.done   = (state_ff == F_DONE);
   assign stat.cfg_ok = ok_ff;
   assign stat.count  = count_ff;

endmodule

### rtl/core/fixed_block_pool_allocator_unit.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_unit
// Fixed-size block pool with a FIFO free list of payload addresses.
// ----------------------------------------------------------------------------
// Usage:
//   req_port carries one command item (allocate, free, initialise, no-op)
//   and a free address; rsp_port returns one result item per command with
//   the allocated address, a status code and the block counts.
//   csr_we/csr_index/csr_wdata write pool_base, pool_bytes and payload_bytes;
//   write them only while no command is in flight.
// Timing:
//   The block takes one command at a time. The result item is loaded into
//   the output register from S_DONE. Free and no-op pass through S_EXEC,
//   allocate also through S_READ for the registered free-list read, and
//   an initialise that builds N blocks, N up to 64, waits in S_INIT for
//   the subtract/add loop on the fill unit's adder, as does a rejected
//   configuration. The next command is taken in the cycle after its result
//   is loaded. A new command is accepted while the previous result still waits.
// Reset:
//   Synchronous, active high. Pool is uninitialised, counts are zero and
//   the free-list memory is left as is.
// Stall:
//   If rsp_port is not taken, the next result waits in its own stage and
//   the block stops taking commands until the output register frees.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_unit (
   input  logic                                clock,
   input  logic                                reset,
   fbpa_req_if.sink                            req_port,
   fbpa_rsp_if.source                          rsp_port,
   input  logic                                csr_we,
   input  logic [fbpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbpa_pkg::CSR_W-1:0]          csr_wdata
);

   localparam logic [fbpa_pkg::CNT_W-1:0] CNT_MAX = fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_READ, S_INIT, S_DONE
   } state_type;

   state_type                        state_ff, state_in;
   fbpa_pkg::cfg_type                cfg_ff;
   fbpa_pkg::cmd_type                cmd_ff;
   logic [fbpa_pkg::ADDR_W-1:0]      faddr_ff;
   logic [fbpa_pkg::IDX_W-1:0]       head_ff, head_in, tail_ff, tail_in;
   logic [fbpa_pkg::CNT_W-1:0]       used_ff, used_in, total_ff, total_in;
   logic                             init_ff, init_in;
   logic [fbpa_pkg::ADDR_W-1:0]      res_addr_ff, res_addr_in;
   fbpa_pkg::status_type             res_st_ff, res_st_in;

   logic                             out_valid_ff, out_valid_in;
   logic [fbpa_pkg::ADDR_W-1:0]      out_addr_ff, out_addr_in;
   fbpa_pkg::status_type             out_st_ff, out_st_in;
   logic [fbpa_pkg::OUT_CNT_W-1:0]   out_total_ff, out_total_in;
   logic [fbpa_pkg::OUT_CNT_W-1:0]   out_used_ff, out_used_in;

   logic                             fill_start;
   fbpa_pkg::fill_stat_type          fill_stat;
   fbpa_pkg::ram_wr_type             fill_wr, push_wr, ram_wr;
   logic [fbpa_pkg::ADDR_W-1:0]      rd_data;
   logic                             req_take, out_free;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            fbpa_pkg::CSR_POOL_BASE:     cfg_ff.base    <= csr_wdata;
            fbpa_pkg::CSR_POOL_BYTES:    cfg_ff.bytes   <= csr_wdata;
            fbpa_pkg::CSR_PAYLOAD_BYTES: cfg_ff.payload <= csr_wdata[fbpa_pkg::PAY_W-1:0];
            default: ;
         endcase
      end
   end

   fbpa_fill_seq u_fill (
      .clock (clock),
      .reset (reset),
      .start (fill_start),
      .cfg   (cfg_ff),
      .stat  (fill_stat),
      .wr    (fill_wr)
   );

   assign ram_wr = fill_wr.en ? fill_wr : push_wr;

   fbpa_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign req_port.ready = (state_ff == S_IDLE);
   assign req_take       = req_port.valid && req_port.ready;
   assign out_free       = !out_valid_ff || rsp_port.ready;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      used_in      = used_ff;
      total_in     = total_ff;
      init_in      = init_ff;
      res_addr_in  = res_addr_ff;
      res_st_in    = res_st_ff;
      fill_start   = 1'b0;
      push_wr.en   = 1'b0;
      push_wr.addr = tail_ff;
      push_wr.data = faddr_ff;
      out_valid_in = out_valid_ff && !rsp_port.ready;
      out_addr_in  = out_addr_ff;
      out_st_in    = out_st_ff;
      out_total_in = out_total_ff;
      out_used_in  = out_used_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            res_addr_in = '0;
            res_st_in   = fbpa_pkg::ST_OK;
            state_in    = S_DONE;
            case (cmd_ff)
               fbpa_pkg::CMD_ALLOC: begin
                  if (!init_ff) begin
                     res_st_in = fbpa_pkg::ST_NOINIT;
                  end else if (used_ff >= total_ff) begin
                     res_st_in = fbpa_pkg::ST_EMPTY;
                  end else begin
                     // head entry is read this cycle, data lands in S_READ
                     head_in  = fbpa_pkg::ring_next(head_ff);
                     used_in  = used_ff + 1'b1;
                     state_in = S_READ;
                  end
               end
               fbpa_pkg::CMD_FREE: begin
                  if (faddr_ff == '0) begin
                     res_st_in = fbpa_pkg::ST_OK;
                  end else if (!init_ff) begin
                     res_st_in = fbpa_pkg::ST_NOINIT;
                  end else if (used_ff == '0) begin
                     res_st_in = fbpa_pkg::ST_UNDERFLOW;
                  end else begin
                     push_wr.en = 1'b1;
                     tail_in    = fbpa_pkg::ring_next(tail_ff);
                     used_in    = used_ff - 1'b1;
                  end
               end
               fbpa_pkg::CMD_INIT: begin
                  fill_start = 1'b1;
                  state_in   = S_INIT;
               end
               default: ;
            endcase
         end
         S_READ: begin
            res_addr_in = rd_data;
            state_in    = S_DONE;
         end
         S_INIT: begin
            if (fill_stat.done) begin
               state_in = S_DONE;
               if (!fill_stat.cfg_ok) begin
                  res_st_in = fbpa_pkg::ST_BADCFG;
               end else begin
                  total_in = fill_stat.count;
                  used_in  = '0;
                  head_in  = '0;
                  tail_in  = (fill_stat.count == CNT_MAX) ? '0 :
                             fill_stat.count[fbpa_pkg::IDX_W-1:0];
                  init_in  = (fill_stat.count != '0);
                  res_st_in = (fill_stat.count != '0) ? fbpa_pkg::ST_OK
                                                      : fbpa_pkg::ST_BADCFG;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_addr_in  = res_addr_ff;
               out_st_in    = res_st_ff;
               out_total_in = fbpa_pkg::OUT_CNT_W'(total_ff);
               out_used_in  = fbpa_pkg::OUT_CNT_W'(used_ff);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         used_ff      <= '0;
         total_ff     <= '0;
         init_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         init_ff      <= init_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_take) begin
         cmd_ff   <= fbpa_pkg::cmd_type'(req_port.command);
         faddr_ff <= req_port.free_addr;
      end
      res_addr_ff  <= res_addr_in;
      res_st_ff    <= res_st_in;
      out_addr_ff  <= out_addr_in;
      out_st_ff    <= out_st_in;
      out_total_ff <= out_total_in;
      out_used_ff  <= out_used_in;
   end

   assign rsp_port.valid         = out_valid_ff;
   assign rsp_port.block_addr    = out_addr_ff;
   assign rsp_port.status        = out_st_ff;
   assign rsp_port.total_blocks  = out_total_ff;
   assign rsp_port.blocks_in_use = out_used_ff;

endmodule
